### rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// each macro checks on the rising clock edge and is disabled while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/hdma_pkg.sv
// shared types, codes and constants of the hex display / adc average block
// no dependencies
`timescale 1ns / 1ps

package hdma_pkg;

  localparam int unsigned AvgSamplesDefault = 256;
  localparam int unsigned AvgShift          = 10;

  localparam logic [7:0] TICK_LIMIT_RST = 8'd61;
  localparam logic [7:0] SHOWN_RST      = 8'hFF;
  localparam logic [7:0] QUERY_BYTE     = 8'h01;
  localparam logic [7:0] SEG_BLANK      = 8'hFF;

  // item kinds
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_RX     = 2'd2;

  // config port
  localparam int unsigned PaddrW         = 3;
  localparam logic [0:0]  REG_TICK_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] sample;
    logic [7:0] rx_byte;
  } hdma_in_t;

  typedef struct packed {
    logic       seg_valid;
    logic [7:0] segments;
    logic       digit_high;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } hdma_out_t;

  // active-low segment pattern of one hex digit
  function automatic logic [7:0] hex_to_seg(input logic [3:0] nib);
    logic [7:0] seg;
    case (nib)
      4'h0:    seg = 8'hC0;
      4'h1:    seg = 8'hF9;
      4'h2:    seg = 8'hA4;
      4'h3:    seg = 8'hB0;
      4'h4:    seg = 8'h99;
      4'h5:    seg = 8'h92;
      4'h6:    seg = 8'h82;
      4'h7:    seg = 8'hF8;
      4'h8:    seg = 8'h80;
      4'h9:    seg = 8'h90;
      4'hA:    seg = 8'h88;
      4'hB:    seg = 8'h83;
      4'hC:    seg = 8'hC6;
      4'hD:    seg = 8'hA1;
      4'hE:    seg = 8'h86;
      default: seg = 8'h8E;
    endcase
    return seg;
  endfunction

endpackage

### rtl/hdma_cfg.sv
// apb-style register file holding the tick limit
// depends on hdma_pkg
`timescale 1ns / 1ps

module hdma_cfg import hdma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        tick_limit_o
);

  logic [7:0] tick_limit_q, tick_limit_d;
  logic [0:0] reg_idx;

  assign reg_idx = paddr[PaddrW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    tick_limit_d = tick_limit_q;
    if (psel && penable && pwrite && (reg_idx == REG_TICK_LIMIT)) begin
      tick_limit_d = pwdata[7:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TICK_LIMIT: prdata = {24'd0, tick_limit_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_limit_q <= TICK_LIMIT_RST;
    end else begin
      tick_limit_q <= tick_limit_d;
    end
  end

  assign tick_limit_o = tick_limit_q;

endmodule

### rtl/hdma_proc.sv
// display and averaging state with the per-request result logic
// depends on hdma_pkg
`timescale 1ns / 1ps

module hdma_proc import hdma_pkg::*; #(
  parameter int unsigned AVG_SAMPLES = AvgSamplesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  hdma_in_t  item_i,
  input  logic [7:0] tick_limit_i,
  output hdma_out_t result_o
);

  localparam int unsigned SumW = AvgShift + $clog2(AVG_SAMPLES);
  localparam int unsigned CntW = $clog2(AVG_SAMPLES + 1);

  logic [7:0]      tick_cnt_q, tick_cnt_d;
  logic [7:0]      shown_q, shown_d;
  logic            toggle_q, toggle_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [7:0]      tick_inc;
  logic [SumW-1:0] sum_inc;
  logic [SumW+7:0] sum_wide;

  assign tick_inc = tick_cnt_q + 8'd1;
  assign sum_inc  = sum_q + SumW'(item_i.sample);
  assign sum_wide = {8'd0, sum_inc};

  always_comb begin
    tick_cnt_d = tick_cnt_q;
    shown_d    = shown_q;
    toggle_d   = toggle_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    result_o   = '{seg_valid: 1'b0, segments: SEG_BLANK, digit_high: 1'b0,
                   tx_valid: 1'b0, tx_byte: 8'd0};
    unique case (item_i.op)
      OP_TICK: begin
        tick_cnt_d = tick_inc;
        if (tick_inc > tick_limit_i) begin
          tick_cnt_d = 8'd0;
          shown_d    = shown_q + 8'd1;
        end
        toggle_d           = ~toggle_q;
        result_o.seg_valid = 1'b1;
        // toggle set shows the low nibble
        if (toggle_d) begin
          result_o.digit_high = 1'b0;
          result_o.segments   = hex_to_seg(shown_d[3:0]);
        end else begin
          result_o.digit_high = 1'b1;
          result_o.segments   = hex_to_seg(shown_d[7:4]);
        end
      end
      OP_SAMPLE: begin
        sum_d = sum_inc;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(AVG_SAMPLES - 1)) begin
          shown_d = sum_wide[AvgShift +: 8];
          sum_d   = '0;
          cnt_d   = '0;
        end
      end
      OP_RX: begin
        if (item_i.rx_byte == QUERY_BYTE) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_byte  = shown_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= 8'd0;
      shown_q    <= SHOWN_RST;
      toggle_q   <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else if (fire_i) begin
      tick_cnt_q <= tick_cnt_d;
      shown_q    <= shown_d;
      toggle_q   <= toggle_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

### rtl/hex_display_mux_adc_average_core.sv
// Two-digit multiplexed hex display driver with an adc sample averager. Each request
// (timer tick, adc sample or serial byte) gives exactly one result once it is taken;
// it is held first in the input register, then in the result register. One request
// is taken every cycle when the output is not stalled; the combinational update of the
// shown byte, tick counter and sample sum sets that rate. tick_limit lives at byte
// address 0 of the apb-style port and should be written only while the block is idle.
// depends on hdma_pkg, hdma_cfg, hdma_proc and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hex_display_mux_adc_average_core import hdma_pkg::*; #(
  parameter int unsigned AVG_SAMPLES = AvgSamplesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hdma_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hdma_out_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic       s1_valid_q, s1_valid_d;
  hdma_in_t   s1_item_q;
  logic       out_valid_q, out_valid_d;
  hdma_out_t  out_data_q;
  hdma_out_t  result;
  logic [7:0] tick_limit;
  logic       out_free, fire, in_take;

  hdma_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_limit_o (tick_limit)
  );

  hdma_proc #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_proc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (s1_item_q),
    .tick_limit_i (tick_limit),
    .result_o     (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_IMP(a_one_kind, out_valid_o, !(out_data_o.seg_valid && out_data_o.tx_valid))
  `ASSERT_IMP(a_blank_seg, out_valid_o && !out_data_o.seg_valid,
              (out_data_o.segments == SEG_BLANK) && !out_data_o.digit_high)
  `ASSERT_IMP(a_blank_tx, out_valid_o && !out_data_o.tx_valid, out_data_o.tx_byte == 8'd0)
  `ASSERT_NEXT(a_stalled_item_kept, in_stall_o, s1_valid_q)

endmodule

### bench/hex_display_mux_adc_average_core_tb.sv
// self-checking bench for hex_display_mux_adc_average_core: directed table, then random phases
// at several tick limits, each result checked against a typed-in value or a local display/averager predictor
// depends on hdma_pkg and the rtl of the core
`timescale 1ns / 1ps

module hex_display_mux_adc_average_core_tb;
  import hdma_pkg::*;

  localparam logic [1:0]        OP_UNUSED       = 2'd3;
  localparam logic [PaddrW-1:0] TICK_LIMIT_ADDR = PaddrW'(REG_TICK_LIMIT) << 2;
  localparam int                HOLD_CYCLES     = 400;
  localparam int                IDLE_LIMIT      = 3000;
  localparam int                N_DIRECTED      = 14;

  // active-low hex patterns, index 15 first
  localparam logic [15:0][7:0] SEG_LUT = {
    8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
    8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  localparam hdma_out_t NO_RESULT = '{seg_valid: 1'b0, segments: SEG_BLANK, digit_high: 1'b0,
                                      tx_valid: 1'b0, tx_byte: 8'h00};

  typedef struct packed {
    logic      known;
    hdma_in_t  req;
    hdma_out_t res;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_r  = 1'b0;
  hdma_in_t          in_data_r   = '0;
  logic              out_stall_r = 1'b0;
  logic              psel_r      = 1'b0;
  logic              penable_r   = 1'b0;
  logic              pwrite_r    = 1'b0;
  logic [PaddrW-1:0] paddr_r     = '0;
  logic [31:0]       pwdata_r    = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  hdma_out_t         out_data_o;
  logic [31:0]       prdata;
  logic              pready;

  // predictor state
  logic [7:0]  tick_lim;
  logic [7:0]  tick_cnt;
  logic [7:0]  shown;
  logic        digit_tog;
  logic [31:0] acc_sum;
  int unsigned acc_n;

  hdma_out_t pending_display_out [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;

  // typed-in results only where they follow directly from reset values
  dir_row_t directed_rows [N_DIRECTED] = '{
    {1'b1, OP_TICK,   10'd0,     8'h00, 1'b1, 8'h8E, 1'b0, 1'b0, 8'h00},
    {1'b1, OP_TICK,   10'd0,     8'h00, 1'b1, 8'h8E, 1'b1, 1'b0, 8'h00},
    {1'b1, OP_RX,     10'd0,     QUERY_BYTE, 1'b0, SEG_BLANK, 1'b0, 1'b1, 8'hFF},
    {1'b1, OP_RX,     10'd0,     8'h00, NO_RESULT},
    {1'b1, OP_RX,     10'd1023,  8'hFF, NO_RESULT},
    {1'b1, OP_RX,     10'd0,     8'hFE, NO_RESULT},
    {1'b1, OP_UNUSED, 10'd1023,  8'hFF, NO_RESULT},
    {1'b1, OP_UNUSED, 10'd0,     8'h00, NO_RESULT},
    {1'b1, OP_SAMPLE, 10'd1023,  8'h00, NO_RESULT},
    {1'b1, OP_SAMPLE, 10'd0,     8'hFF, NO_RESULT},
    {1'b0, OP_SAMPLE, 10'h2AA,   8'h55, NO_RESULT},
    {1'b0, OP_SAMPLE, 10'h155,   8'hAA, NO_RESULT},
    {1'b0, OP_TICK,   10'h3FF,   8'h01, NO_RESULT},
    {1'b1, OP_RX,     10'd0,     QUERY_BYTE, 1'b0, SEG_BLANK, 1'b0, 1'b1, 8'hFF}
  };

  hex_display_mux_adc_average_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_r),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_r),
    .out_data_o  (out_data_o),
    .psel        (psel_r),
    .penable     (penable_r),
    .pwrite      (pwrite_r),
    .paddr       (paddr_r),
    .pwdata      (pwdata_r),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic hdma_out_t next_display(hdma_in_t req);
    hdma_out_t r;
    r = NO_RESULT;
    case (req.op)
      OP_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > tick_lim) begin
          tick_cnt = 8'd0;
          shown    = shown + 8'd1;
        end
        digit_tog   = ~digit_tog;
        r.seg_valid = 1'b1;
        if (digit_tog) begin
          r.digit_high = 1'b0;
          r.segments   = SEG_LUT[shown[3:0]];
        end else begin
          r.digit_high = 1'b1;
          r.segments   = SEG_LUT[shown[7:4]];
        end
      end
      OP_SAMPLE: begin
        acc_sum = acc_sum + 32'(req.sample);
        acc_n   = acc_n + 1;
        if (acc_n >= AvgSamplesDefault) begin
          shown   = acc_sum[AvgShift +: 8];
          acc_sum = '0;
          acc_n   = 0;
        end
      end
      OP_RX: begin
        if (req.rx_byte == QUERY_BYTE) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = shown;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // present one request and hold it until taken
  task automatic offer(hdma_in_t req, bit known, hdma_out_t typed);
    hdma_out_t pred;
    in_valid_r <= 1'b1;
    in_data_r  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pred = next_display(req);
    pending_display_out.push_back(known ? typed : pred);
  endtask

  task automatic wait_idle();
    in_valid_r <= 1'b0;
    while (pending_display_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel_r    <= 1'b1;
    penable_r <= 1'b0;
    pwrite_r  <= wr;
    paddr_r   <= TICK_LIMIT_ADDR;
    pwdata_r  <= wdata;
    @(posedge clk_i);
    penable_r <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel_r    <= 1'b0;
    penable_r <= 1'b0;
    pwrite_r  <= 1'b0;
  endtask

  task automatic read_tick_limit();
    logic [31:0] rd;
    apb_access(1'b0, 32'h0, rd);
    if (rd !== {24'h0, tick_lim}) begin
      $display("%0t: tick_limit readback mismatch, expected %h, actual %h",
               $time, {24'h0, tick_lim}, rd);
      mismatches++;
    end
  endtask

  task automatic set_tick_limit(logic [7:0] lim);
    logic [31:0] rd;
    apb_access(1'b1, {24'h0, lim}, rd);
    tick_lim = lim;
    read_tick_limit();
  endtask

  task automatic run_phase(int n, int tick_pct, int smp_pct, int smp_mode);
    int       sent;
    int       burst;
    int       gap;
    int       r;
    hdma_in_t req;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < n) begin
          req.sample  = 10'($urandom);
          req.rx_byte = 8'($urandom);
          r = $urandom_range(0, 99);
          if (r < tick_pct) begin
            req.op = OP_TICK;
          end else if (r < tick_pct + smp_pct) begin
            req.op = OP_SAMPLE;
            r = $urandom_range(0, 99);
            case (smp_mode)
              1:       req.sample = (r < 50) ? 10'h3FF : 10'($urandom_range(896, 1023));
              2:       req.sample = (r < 50) ? 10'h000 : 10'($urandom_range(0, 127));
              default: begin
                if (r < 15) req.sample = 10'h3FF;
                else if (r < 30) req.sample = 10'h000;
              end
            endcase
          end else if (r < 97) begin
            req.op = OP_RX;
            if ($urandom_range(0, 1) == 0) req.rx_byte = QUERY_BYTE;
          end else begin
            req.op = OP_UNUSED;
          end
          offer(req, 1'b0, NO_RESULT);
          sent++;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_r <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stimulus and end of run
  initial begin : stimulus
    int         i;
    logic [7:0] lim;
    tick_lim  = TICK_LIMIT_RST;
    tick_cnt  = 8'd0;
    shown     = SHOWN_RST;
    digit_tog = 1'b0;
    acc_sum   = '0;
    acc_n     = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    read_tick_limit();
    for (i = 0; i < N_DIRECTED; i++) begin
      offer(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);
    end
    wait_idle();
    for (i = 0; i < 5; i++) begin
      case (i)
        0:       lim = 8'd0;
        1:       lim = 8'd254;
        2:       lim = 8'd255;
        3:       lim = 8'($urandom_range(1, 253));
        default: lim = TICK_LIMIT_RST;
      endcase
      set_tick_limit(lim);
      // long receiver hold-off while requests keep coming
      if (i == 3) hold_req = 1'b1;
      if (lim >= 8'd254) run_phase(360, 80, 15, i % 3);
      else run_phase(320, 30, 60, i % 3);
      wait_idle();
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver stall pattern
  initial begin : receiver
    int mode;
    int len;
    int k;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_stall_r <= 1'b1;
        end
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 48);
      for (k = 0; k < len; k++) begin
        @(posedge clk_i);
        case (mode)
          0:       out_stall_r <= 1'b0;
          1:       out_stall_r <= ($urandom_range(0, 99) < 25);
          2:       out_stall_r <= ($urandom_range(0, 99) < 75);
          default: out_stall_r <= (k % 3 == 2);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    hdma_out_t want;
    if (rst_ni && out_valid_o && !out_stall_r) begin
      if (pending_display_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_display_out.pop_front();
        check_field("seg_valid", 8'(want.seg_valid), 8'(out_data_o.seg_valid));
        check_field("segments", want.segments, out_data_o.segments);
        check_field("digit_high", 8'(want.digit_high), 8'(out_data_o.digit_high));
        check_field("tx_valid", 8'(want.tx_valid), 8'(out_data_o.tx_valid));
        check_field("tx_byte", want.tx_byte, out_data_o.tx_byte);
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_r && !in_stall_o) || (out_valid_o && !out_stall_r) ||
        (psel_r && penable_r)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
